>>> rtl/pgbu_pkg.sv
// ----------------------------------------------------------------------------
// pgbu_pkg
// types, constants and codes shared by the gravity body update block
// ----------------------------------------------------------------------------
package pgbu_pkg;

    localparam int NUM_BODIES = 64;
    localparam int BODY_W     = $clog2(NUM_BODIES);
    localparam int BODY_IN_W  = 6;

    localparam int POS_W      = 64;
    localparam int VEL_W      = 48;
    localparam int MASS_W     = 48;
    localparam int GRAV_W     = 64;
    localparam int AXES       = 3;

    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_LSB = 3;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_ADDR_W   = CFG_ADDR_LSB + CFG_IDX_W;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV_IDX = 1'b0;

    // interaction datapath widths
    localparam int L1_W    = POS_W + 2;
    localparam int D2_W    = 2 * POS_W + 2;
    localparam int MUL_Y_W = L1_W;
    localparam int MUL_X_W = D2_W + L1_W;
    localparam int DEN_W   = MUL_X_W;
    localparam int NA_W    = GRAV_W + MASS_W;
    localparam int NUM_W   = NA_W + POS_W;
    localparam int QUO_W   = 48;
    localparam int MAG_W   = QUO_W + 1;
    localparam int REM_W   = DEN_W + 1;
    localparam int CNT_W   = $clog2(MUL_Y_W);
    localparam int SUM_W   = VEL_W + 2;
    localparam int AX_W    = 2;

    localparam logic [MAG_W-1:0] MAG_CAP = {1'b1, {QUO_W{1'b0}}};
    localparam logic [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
    localparam logic [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_PAIR = 2'd1;
    localparam logic [1:0] REQ_MOVE = 2'd2;
    localparam logic [1:0] REQ_READ = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COINC = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    typedef logic [AXES-1:0][POS_W-1:0] pos_vec_t;
    typedef logic [AXES-1:0][VEL_W-1:0] vel_vec_t;

    typedef struct packed {
        pos_vec_t            pos;
        vel_vec_t            vel;
        logic [MASS_W-1:0]   mass;
    } body_t;

    typedef struct packed {
        logic start;
    } pair_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic coinc;
        logic sat;
    } pair_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_A,
        S_CAP_A,
        S_CAP_B,
        S_MOVE,
        S_PAIR_GO,
        S_PAIR_WAIT,
        S_WRITE_A,
        S_WRITE_B,
        S_FINISH
    } top_state_t;

    typedef enum logic [2:0] {
        P_IDLE,
        P_CHECK,
        P_LAUNCH,
        P_MUL,
        P_POST,
        P_DIV_CHK,
        P_DIV,
        P_UPD
    } pair_state_t;

    typedef enum logic [2:0] {
        OP_SQ,
        OP_DEN,
        OP_NA,
        OP_NB,
        OP_NUM
    } pair_op_t;

endpackage

>>> rtl/pgbu_pair_unit.sv
// ----------------------------------------------------------------------------
// pgbu_pair_unit
// pairwise gravity interaction: shift-add multiplier and bit-serial divider
// shared over all products and quotients of one interaction
// ----------------------------------------------------------------------------
module pgbu_pair_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pgbu_pkg::pair_ctrl_t        ctrl,
    output pgbu_pkg::pair_stat_t        stat,
    input  logic [pgbu_pkg::GRAV_W-1:0] grav,
    input  pgbu_pkg::pos_vec_t          pos_a,
    input  pgbu_pkg::pos_vec_t          pos_b,
    input  pgbu_pkg::vel_vec_t          vel_a,
    input  pgbu_pkg::vel_vec_t          vel_b,
    input  logic [pgbu_pkg::MASS_W-1:0] mass_a,
    input  logic [pgbu_pkg::MASS_W-1:0] mass_b,
    output pgbu_pkg::vel_vec_t          new_vel_a,
    output pgbu_pkg::vel_vec_t          new_vel_b
);
    import pgbu_pkg::*;

    pair_state_t              state_reg, state_next;
    pair_op_t                 op_reg;
    logic [AX_W-1:0]          ax_reg;
    logic                     side_reg;
    pos_vec_t                 dd_reg;
    logic [AXES-1:0]          a_gt_reg;
    logic [D2_W-1:0]          d2_reg;
    logic [L1_W-1:0]          l1_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [NA_W-1:0]          na_reg;
    logic [NA_W-1:0]          nb_reg;
    logic [MUL_X_W-1:0]       mul_x_reg;
    logic [MUL_Y_W-1:0]       mul_y_reg;
    logic [MUL_X_W-1:0]       acc_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [REM_W-1:0]         rem_reg;
    logic [QUO_W-1:0]         nlow_reg;
    logic [QUO_W-1:0]         quo_reg;
    logic [MAG_W-1:0]         mag_reg;
    vel_vec_t                 va_reg;
    vel_vec_t                 vb_reg;
    logic                     sat_reg;

    pos_vec_t                 dd_calc;
    logic [AXES-1:0]          gt_calc;
    logic [MUL_X_W-1:0]       op_x;
    logic [MUL_Y_W-1:0]       op_y;
    logic [REM_W-1:0]         rem_shift;
    logic                     rem_ge;
    logic [QUO_W-1:0]         quo_next;
    logic [VEL_W-1:0]         v_sel;
    logic                     neg_sel;
    logic [SUM_W-1:0]         v_ext;
    logic [SUM_W-1:0]         upd_sum;
    logic                     upd_fits;
    logic [VEL_W-1:0]         upd_val;
    logic                     upd_apply;
    logic                     mul_last;
    logic                     div_last;
    logic                     last_upd;

    // offsets and direction
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            gt_calc[i] = $signed(pos_a[i]) > $signed(pos_b[i]);
            dd_calc[i] = gt_calc[i] ? (pos_a[i] - pos_b[i]) : (pos_b[i] - pos_a[i]);
        end
    end

    // multiplier operand selection
    always_comb
    begin
        op_x = '0;
        op_y = '0;
        case (op_reg)
            OP_SQ:
            begin
                op_x = MUL_X_W'(dd_reg[ax_reg]);
                op_y = MUL_Y_W'(dd_reg[ax_reg]);
            end
            OP_DEN:
            begin
                op_x = MUL_X_W'(d2_reg);
                op_y = l1_reg;
            end
            OP_NA:
            begin
                op_x = MUL_X_W'(grav);
                op_y = MUL_Y_W'(mass_b);
            end
            OP_NB:
            begin
                op_x = MUL_X_W'(grav);
                op_y = MUL_Y_W'(mass_a);
            end
            OP_NUM:
            begin
                op_x = side_reg ? MUL_X_W'(nb_reg) : MUL_X_W'(na_reg);
                op_y = MUL_Y_W'(dd_reg[ax_reg]);
            end
            default:
            begin
                op_x = '0;
                op_y = '0;
            end
        endcase
    end

    // divider step
    assign rem_shift = {rem_reg[REM_W-2:0], nlow_reg[QUO_W-1]};
    assign rem_ge    = rem_shift >= {1'b0, den_reg};
    assign quo_next  = {quo_reg[QUO_W-2:0], rem_ge};

    // velocity update with clamping
    assign v_sel     = side_reg ? vb_reg[ax_reg] : va_reg[ax_reg];
    assign neg_sel   = side_reg ? !a_gt_reg[ax_reg] : a_gt_reg[ax_reg];
    assign v_ext     = {{(SUM_W-VEL_W){v_sel[VEL_W-1]}}, v_sel};
    assign upd_sum   = neg_sel ? (v_ext - SUM_W'(mag_reg)) : (v_ext + SUM_W'(mag_reg));
    assign upd_fits  = (upd_sum[SUM_W-1:VEL_W-1] == '0) || (upd_sum[SUM_W-1:VEL_W-1] == '1);
    assign upd_val   = upd_fits ? upd_sum[VEL_W-1:0] : (upd_sum[SUM_W-1] ? VEL_MIN : VEL_MAX);
    assign upd_apply = side_reg ? (mass_b != '0) : (mass_a != '0);

    assign mul_last  = cnt_reg == CNT_W'(MUL_Y_W - 1);
    assign div_last  = cnt_reg == CNT_W'(QUO_W - 1);
    assign last_upd  = side_reg && (ax_reg == AX_W'(AXES - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            P_IDLE:
                if (ctrl.start)
                    state_next = P_CHECK;
            P_CHECK:
                state_next = (dd_reg == '0) ? P_IDLE : P_LAUNCH;
            P_LAUNCH:
                state_next = P_MUL;
            P_MUL:
                if (mul_last)
                    state_next = P_POST;
            P_POST:
                state_next = (op_reg == OP_NUM) ? P_DIV_CHK : P_LAUNCH;
            P_DIV_CHK:
                state_next = (rem_reg >= {1'b0, den_reg}) ? P_UPD : P_DIV;
            P_DIV:
                if (div_last)
                    state_next = P_UPD;
            P_UPD:
                state_next = last_upd ? P_IDLE : P_LAUNCH;
            default:
                state_next = P_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        stat.busy  = state_reg != P_IDLE;
        stat.done  = ((state_reg == P_CHECK) && (dd_reg == '0))
                     || ((state_reg == P_UPD) && last_upd);
        stat.coinc = (state_reg == P_CHECK) && (dd_reg == '0);
        stat.sat   = sat_reg || ((state_reg == P_UPD) && upd_apply && !upd_fits);
        new_vel_a  = va_reg;
        new_vel_b  = vb_reg;
        if ((state_reg == P_UPD) && upd_apply)
        begin
            if (side_reg)
                new_vel_b[ax_reg] = upd_val;
            else
                new_vel_a[ax_reg] = upd_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= P_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            P_IDLE:
                if (ctrl.start)
                begin
                    dd_reg    <= dd_calc;
                    a_gt_reg  <= gt_calc;
                    va_reg    <= vel_a;
                    vb_reg    <= vel_b;
                    sat_reg   <= 1'b0;
                end
            P_CHECK:
            begin
                l1_reg    <= L1_W'(dd_reg[0]) + L1_W'(dd_reg[1]) + L1_W'(dd_reg[2]);
                d2_reg    <= '0;
                op_reg    <= OP_SQ;
                ax_reg    <= '0;
                side_reg  <= 1'b0;
            end
            P_LAUNCH:
            begin
                mul_x_reg <= op_x;
                mul_y_reg <= op_y;
                acc_reg   <= '0;
                cnt_reg   <= '0;
            end
            P_MUL:
            begin
                if (mul_y_reg[0])
                    acc_reg <= acc_reg + mul_x_reg;
                mul_x_reg <= {mul_x_reg[MUL_X_W-2:0], 1'b0};
                mul_y_reg <= {1'b0, mul_y_reg[MUL_Y_W-1:1]};
                cnt_reg   <= cnt_reg + CNT_W'(1);
            end
            P_POST:
                case (op_reg)
                    OP_SQ:
                    begin
                        d2_reg <= d2_reg + acc_reg[D2_W-1:0];
                        if (ax_reg == AX_W'(AXES - 1))
                        begin
                            op_reg <= OP_DEN;
                            ax_reg <= '0;
                        end
                        else
                            ax_reg <= ax_reg + AX_W'(1);
                    end
                    OP_DEN:
                    begin
                        den_reg <= acc_reg;
                        op_reg  <= OP_NA;
                    end
                    OP_NA:
                    begin
                        na_reg <= acc_reg[NA_W-1:0];
                        op_reg <= OP_NB;
                    end
                    OP_NB:
                    begin
                        nb_reg   <= acc_reg[NA_W-1:0];
                        op_reg   <= OP_NUM;
                        ax_reg   <= '0;
                        side_reg <= 1'b0;
                    end
                    default:
                    begin
                        rem_reg  <= REM_W'(acc_reg[NUM_W-1:QUO_W]);
                        nlow_reg <= acc_reg[QUO_W-1:0];
                        quo_reg  <= '0;
                        cnt_reg  <= '0;
                    end
                endcase
            P_DIV_CHK:
                if (rem_reg >= {1'b0, den_reg})
                    mag_reg <= MAG_CAP;
            P_DIV:
            begin
                rem_reg  <= rem_ge ? (rem_shift - {1'b0, den_reg}) : rem_shift;
                quo_reg  <= quo_next;
                nlow_reg <= {nlow_reg[QUO_W-2:0], 1'b0};
                cnt_reg  <= cnt_reg + CNT_W'(1);
                if (div_last)
                    mag_reg <= MAG_W'(quo_next);
            end
            P_UPD:
            begin
                va_reg  <= new_vel_a;
                vb_reg  <= new_vel_b;
                sat_reg <= stat.sat;
                if (side_reg)
                begin
                    side_reg <= 1'b0;
                    ax_reg   <= ax_reg + AX_W'(1);
                end
                else
                    side_reg <= 1'b1;
            end
            default:
                sat_reg <= sat_reg;
        endcase
    end

endmodule

>>> rtl/pairwise_gravity_body_update_top.sv
// ----------------------------------------------------------------------------
// pairwise_gravity_body_update_top
// body table with load, read, move and pairwise gravity interaction requests
// ----------------------------------------------------------------------------
// The body records (position, velocity, mass) live in one synchronous memory
// of NUM_BODIES entries with a registered read; entries are undefined until
// loaded. One request is worked on at a time and every request returns one
// result transaction. A pair interaction runs twelve products on a
// shift-and-add multiplier and six quotients on a bit-serial divider, plus
// memory reads and the two write-backs; coincident bodies skip the products,
// the quotients and the write-backs. A new request is taken while the
// previous result still waits in the output register.
// grav_constant sits at byte address 0 of the 64-bit register port.
module pairwise_gravity_body_update_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pgbu_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [pgbu_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [pgbu_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      req_type,
    input  logic [pgbu_pkg::BODY_IN_W-1:0]  body_a,
    input  logic [pgbu_pkg::BODY_IN_W-1:0]  body_b,
    input  logic signed [63:0]              load_pos_x,
    input  logic signed [63:0]              load_pos_y,
    input  logic signed [63:0]              load_pos_z,
    input  logic signed [47:0]              load_vel_x,
    input  logic signed [47:0]              load_vel_y,
    input  logic signed [47:0]              load_vel_z,
    input  logic [47:0]                     load_mass,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [63:0]              out_pos_x,
    output logic signed [63:0]              out_pos_y,
    output logic signed [63:0]              out_pos_z,
    output logic signed [47:0]              out_vel_x,
    output logic signed [47:0]              out_vel_y,
    output logic signed [47:0]              out_vel_z,
    output logic [47:0]                     out_mass,
    output logic [1:0]                      status
);
    import pgbu_pkg::*;

    top_state_t          state_reg, state_next;
    logic [GRAV_W-1:0]   grav_reg;
    logic [1:0]          req_reg;
    logic [BODY_W-1:0]   a_reg;
    logic [BODY_W-1:0]   b_reg;
    body_t               rec_a_reg;
    body_t               rec_b_reg;
    logic [1:0]          status_reg;
    body_t               out_rec_reg;
    logic [1:0]          out_status_reg;
    logic                out_valid_reg;

    body_t               mem [NUM_BODIES];
    body_t               rd_data_reg;
    logic                mem_we;
    logic [BODY_W-1:0]   mem_wa;
    logic [BODY_W-1:0]   mem_ra;
    body_t               mem_wd;

    logic                cfg_wr;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic                finish_go;

    pair_ctrl_t          pair_ctrl;
    pair_stat_t          pair_stat;
    vel_vec_t            new_vel_a;
    vel_vec_t            new_vel_b;

    pos_vec_t            mv_pos;
    logic [AXES-1:0]     mv_ovf;

    pgbu_pair_unit u_pair (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (pair_ctrl),
        .stat      (pair_stat),
        .grav      (grav_reg),
        .pos_a     (rec_a_reg.pos),
        .pos_b     (rec_b_reg.pos),
        .vel_a     (rec_a_reg.vel),
        .vel_b     (rec_b_reg.vel),
        .mass_a    (rec_a_reg.mass),
        .mass_b    (rec_b_reg.mass),
        .new_vel_a (new_vel_a),
        .new_vel_b (new_vel_b)
    );

    // register port
    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:CFG_ADDR_LSB];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = (cfg_idx == CFG_GRAV_IDX) ? grav_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grav_reg <= '0;
        else if (cfg_wr && (cfg_idx == CFG_GRAV_IDX))
            grav_reg <= pwdata;
    end

    // saturating move
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            mv_pos[i] = rec_a_reg.pos[i]
                        + {{(POS_W-VEL_W){rec_a_reg.vel[i][VEL_W-1]}}, rec_a_reg.vel[i]};
            mv_ovf[i] = (rec_a_reg.pos[i][POS_W-1] == rec_a_reg.vel[i][VEL_W-1])
                        && (mv_pos[i][POS_W-1] != rec_a_reg.pos[i][POS_W-1]);
            if (mv_ovf[i])
                mv_pos[i] = rec_a_reg.pos[i][POS_W-1] ? POS_MIN : POS_MAX;
        end
    end

    assign finish_go = (state_reg == S_FINISH) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (req_type == REQ_LOAD) ? S_WRITE_A : S_RD_A;
            S_RD_A:
                state_next = S_CAP_A;
            S_CAP_A:
                case (req_reg)
                    REQ_READ: state_next = S_FINISH;
                    REQ_MOVE: state_next = S_MOVE;
                    default:  state_next = S_CAP_B;
                endcase
            S_CAP_B:
                state_next = S_PAIR_GO;
            S_PAIR_GO:
                state_next = S_PAIR_WAIT;
            S_PAIR_WAIT:
                if (pair_stat.done)
                    state_next = pair_stat.coinc ? S_FINISH : S_WRITE_A;
            S_MOVE:
                state_next = S_WRITE_A;
            S_WRITE_A:
                state_next = (req_reg == REQ_PAIR) ? S_WRITE_B : S_FINISH;
            S_WRITE_B:
                state_next = S_FINISH;
            S_FINISH:
                if (finish_go)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready        = state_reg == S_IDLE;
        mem_ra          = (state_reg == S_RD_A) ? a_reg : b_reg;
        mem_we          = (state_reg == S_WRITE_A) || (state_reg == S_WRITE_B);
        mem_wa          = (state_reg == S_WRITE_B) ? b_reg : a_reg;
        mem_wd          = (state_reg == S_WRITE_B) ? rec_b_reg : rec_a_reg;
        pair_ctrl.start = state_reg == S_PAIR_GO;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish_go)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // body memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[mem_ra];
    end

    // working records
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    req_reg           <= req_type;
                    a_reg             <= body_a[BODY_W-1:0];
                    b_reg             <= body_b[BODY_W-1:0];
                    rec_a_reg.pos[0]  <= load_pos_x;
                    rec_a_reg.pos[1]  <= load_pos_y;
                    rec_a_reg.pos[2]  <= load_pos_z;
                    rec_a_reg.vel[0]  <= load_vel_x;
                    rec_a_reg.vel[1]  <= load_vel_y;
                    rec_a_reg.vel[2]  <= load_vel_z;
                    rec_a_reg.mass    <= load_mass;
                    status_reg        <= ST_OK;
                end
            S_CAP_A:
                rec_a_reg <= rd_data_reg;
            S_CAP_B:
                rec_b_reg <= rd_data_reg;
            S_PAIR_WAIT:
                if (pair_stat.done)
                begin
                    if (pair_stat.coinc)
                        status_reg <= ST_COINC;
                    else
                    begin
                        rec_a_reg.vel <= new_vel_a;
                        rec_b_reg.vel <= new_vel_b;
                        status_reg    <= pair_stat.sat ? ST_SAT : ST_OK;
                    end
                end
            S_MOVE:
            begin
                rec_a_reg.pos <= mv_pos;
                status_reg    <= (mv_ovf != '0) ? ST_SAT : ST_OK;
            end
            S_FINISH:
                if (finish_go)
                begin
                    out_rec_reg    <= rec_a_reg;
                    out_status_reg <= status_reg;
                end
            default:
                status_reg <= status_reg;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_pos_x = out_rec_reg.pos[0];
    assign out_pos_y = out_rec_reg.pos[1];
    assign out_pos_z = out_rec_reg.pos[2];
    assign out_vel_x = out_rec_reg.vel[0];
    assign out_vel_y = out_rec_reg.vel[1];
    assign out_vel_z = out_rec_reg.vel[2];
    assign out_mass  = out_rec_reg.mass;
    assign status    = out_status_reg;

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg != S_IDLE))
        else $error("accepted transaction left the sequencer idle");

    assert property (@(posedge clk) disable iff (!rst_n)
        pair_stat.done |-> (state_reg == S_PAIR_WAIT))
        else $error("interaction finished while not awaited");

    assert property (@(posedge clk) disable iff (!rst_n)
        pair_ctrl.start |-> !pair_stat.busy)
        else $error("interaction started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !out_ready)
        |=> (state_reg == S_FINISH && $stable(out_rec_reg)))
        else $error("result overwritten while output stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_status_reg == ST_OK || out_status_reg == ST_COINC
                           || out_status_reg == ST_SAT))
        else $error("undefined status code");
`endif

endmodule
